[sv/mkf_pkg.sv]
// shared constants, types and code tables of the farnsworth morse keyer
package mkf_pkg;

    localparam int MAX_BEEPS    = 16;
    localparam int MAX_ELEMENTS = 6;

    localparam int BEEP_W  = $clog2(MAX_BEEPS + 1);
    localparam int ELEM_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int DUR_W   = 16;
    localparam int WPM_W   = 6;
    localparam int BCNT_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [WPM_W-1:0] WPM_LOW     = 6'd5;
    localparam logic [WPM_W-1:0] WPM_HIGH    = 6'd60;
    localparam logic [WPM_W-1:0] WPM_DEFAULT = 6'd20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WPM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FARNS_WPM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_COUNT = 2'd2;

    // 2^16 / 19 rounded up, exact for operands below 2048
    localparam logic [11:0] RECIP_19 = 12'd3450;

    // segment kinds
    localparam logic [2:0] SEG_BEEP_ON  = 3'd0;
    localparam logic [2:0] SEG_BEEP_OFF = 3'd1;
    localparam logic [2:0] SEG_PRE_GAP  = 3'd2;
    localparam logic [2:0] SEG_SPACE    = 3'd3;
    localparam logic [2:0] SEG_LGAP     = 3'd4;
    localparam logic [2:0] SEG_ELEM_ON  = 3'd5;
    localparam logic [2:0] SEG_ELEM_OFF = 3'd6;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] seg;
        logic       inc_beep;
        logic       inc_elem;
        logic       set_prev;
        logic       clr_prev;
    } mkf_cmd_t;

    typedef struct packed {
        logic som;
        logic beeps_zero;
        logic beep_last;
        logic is_space;
        logic prev_sym;
        logic no_elems;
        logic elem_last;
        logic out_free;
    } mkf_status_t;

    function automatic logic [WPM_W-1:0] wpm_clamp(input logic [WPM_W-1:0] w);
        logic [WPM_W-1:0] r;
        r = w;
        if (w < WPM_LOW || w > WPM_HIGH)
            r = WPM_DEFAULT;
        return r;
    endfunction

    // (120 + w/2) / w for w in 5..60
    function automatic logic [4:0] dot_units(input logic [WPM_W-1:0] w);
        logic [4:0] r;
        case (w)
            6'd5:  r = 5'd24;
            6'd6:  r = 5'd20;
            6'd7:  r = 5'd17;
            6'd8:  r = 5'd15;
            6'd9:  r = 5'd13;
            6'd10: r = 5'd12;
            6'd11: r = 5'd11;
            6'd12: r = 5'd10;
            6'd13, 6'd14: r = 5'd9;
            6'd15, 6'd16: r = 5'd8;
            6'd17, 6'd18: r = 5'd7;
            6'd19, 6'd20, 6'd21: r = 5'd6;
            6'd22, 6'd23, 6'd24, 6'd25, 6'd26: r = 5'd5;
            6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34: r = 5'd4;
            6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
            6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48: r = 5'd3;
            6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54,
            6'd55, 6'd56, 6'd57, 6'd58, 6'd59, 6'd60: r = 5'd2;
            default: r = 5'd6;
        endcase
        return r;
    endfunction

    // (6000 + w/2) / w for w in 5..60, PARIS word in dot units
    function automatic logic [10:0] word_units(input logic [WPM_W-1:0] w);
        logic [10:0] r;
        case (w)
            6'd5:  r = 11'd1200;
            6'd6:  r = 11'd1000;
            6'd7:  r = 11'd857;
            6'd8:  r = 11'd750;
            6'd9:  r = 11'd667;
            6'd10: r = 11'd600;
            6'd11: r = 11'd545;
            6'd12: r = 11'd500;
            6'd13: r = 11'd462;
            6'd14: r = 11'd429;
            6'd15: r = 11'd400;
            6'd16: r = 11'd375;
            6'd17: r = 11'd353;
            6'd18: r = 11'd333;
            6'd19: r = 11'd316;
            6'd20: r = 11'd300;
            6'd21: r = 11'd286;
            6'd22: r = 11'd273;
            6'd23: r = 11'd261;
            6'd24: r = 11'd250;
            6'd25: r = 11'd240;
            6'd26: r = 11'd231;
            6'd27: r = 11'd222;
            6'd28: r = 11'd214;
            6'd29: r = 11'd207;
            6'd30: r = 11'd200;
            6'd31: r = 11'd194;
            6'd32: r = 11'd188;
            6'd33: r = 11'd182;
            6'd34: r = 11'd176;
            6'd35: r = 11'd171;
            6'd36: r = 11'd167;
            6'd37: r = 11'd162;
            6'd38: r = 11'd158;
            6'd39: r = 11'd154;
            6'd40: r = 11'd150;
            6'd41: r = 11'd146;
            6'd42: r = 11'd143;
            6'd43: r = 11'd140;
            6'd44: r = 11'd136;
            6'd45: r = 11'd133;
            6'd46: r = 11'd130;
            6'd47: r = 11'd128;
            6'd48: r = 11'd125;
            6'd49: r = 11'd122;
            6'd50: r = 11'd120;
            6'd51: r = 11'd118;
            6'd52: r = 11'd115;
            6'd53: r = 11'd113;
            6'd54: r = 11'd111;
            6'd55: r = 11'd109;
            6'd56: r = 11'd107;
            6'd57: r = 11'd105;
            6'd58: r = 11'd103;
            6'd59: r = 11'd102;
            6'd60: r = 11'd100;
            default: r = 11'd300;
        endcase
        return r;
    endfunction

    // marker bit then elements msb first, 1 = dash; zero for unknown
    function automatic logic [7:0] lookup_code(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] r;
        u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        case (u)
            8'h41: r = 8'h05;
            8'h42: r = 8'h18;
            8'h43: r = 8'h1A;
            8'h44: r = 8'h0C;
            8'h45: r = 8'h02;
            8'h46: r = 8'h12;
            8'h47: r = 8'h0E;
            8'h48: r = 8'h10;
            8'h49: r = 8'h04;
            8'h4A: r = 8'h17;
            8'h4B: r = 8'h0D;
            8'h4C: r = 8'h14;
            8'h4D: r = 8'h07;
            8'h4E: r = 8'h06;
            8'h4F: r = 8'h0F;
            8'h50: r = 8'h16;
            8'h51: r = 8'h1D;
            8'h52: r = 8'h0A;
            8'h53: r = 8'h08;
            8'h54: r = 8'h03;
            8'h55: r = 8'h09;
            8'h56: r = 8'h11;
            8'h57: r = 8'h0B;
            8'h58: r = 8'h19;
            8'h59: r = 8'h1B;
            8'h5A: r = 8'h1C;
            8'h30: r = 8'h3F;
            8'h31: r = 8'h2F;
            8'h32: r = 8'h27;
            8'h33: r = 8'h23;
            8'h34: r = 8'h21;
            8'h35: r = 8'h20;
            8'h36: r = 8'h30;
            8'h37: r = 8'h38;
            8'h38: r = 8'h3C;
            8'h39: r = 8'h3E;
            8'h2F: r = 8'h32;
            8'h2D: r = 8'h61;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // number of elements: position of the marker bit, capped
    function automatic logic [ELEM_W-1:0] code_len(input logic [7:0] code);
        logic [ELEM_W-1:0] r;
        r = '0;
        for (int i = 1; i < 8; i++) begin
            if (code[i])
                r = ELEM_W'(i);
        end
        if (int'(r) > MAX_ELEMENTS)
            r = ELEM_W'(MAX_ELEMENTS);
        return r;
    endfunction

endpackage

[sv/mkf_char_if.sv]
// character input channel
interface mkf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_message;

    modport source (output valid, output char_code, output start_of_message, input ready);
    modport sink   (input valid, input char_code, input start_of_message, output ready);
endinterface

[sv/mkf_seg_if.sv]
// key segment output channel
interface mkf_seg_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] duration_ms;
    logic        is_preamble;
    logic        last_of_run;

    modport source (output valid, output tone_on, output duration_ms,
                    output is_preamble, output last_of_run, input ready);
    modport sink   (input valid, input tone_on, input duration_ms,
                    input is_preamble, input last_of_run, output ready);
endinterface

[sv/mkf_timing.sv]
// configuration registers and two-stage dot / gap unit computation
module mkf_timing
    import mkf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WPM_W-1:0]     cfg_wdata,
    output logic [DUR_W-1:0]     dot_ms,
    output logic [DUR_W-1:0]     gap_ms,
    output logic [BEEP_W-1:0]    beeps
);

    logic [WPM_W-1:0]  char_wpm_reg;
    logic [WPM_W-1:0]  farns_wpm_reg;
    logic [BCNT_W-1:0] beep_count_reg;

    logic [4:0]  dot_t_reg, dot_t_next;
    logic [10:0] word_t_reg, word_t_next;
    logic [9:0]  elem_t_reg, elem_t_next;
    logic        slow_reg, slow_next;
    logic [DUR_W-1:0] dot_ms_reg, dot_ms_next;
    logic [DUR_W-1:0] gap_unit_ms_reg, gap_unit_ms_next;

    logic [WPM_W-1:0] cw, ew;
    logic [10:0] diff;
    logic [22:0] prod;
    logic [6:0]  q, g;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            char_wpm_reg   <= WPM_DEFAULT;
            farns_wpm_reg  <= WPM_DEFAULT;
            beep_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CHAR_WPM:   char_wpm_reg   <= cfg_wdata;
                CFG_FARNS_WPM:  farns_wpm_reg  <= cfg_wdata;
                CFG_BEEP_COUNT: beep_count_reg <= cfg_wdata[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: table lookups and element time
    always_comb begin
        cw          = wpm_clamp(char_wpm_reg);
        ew          = wpm_clamp(farns_wpm_reg);
        dot_t_next  = dot_units(cw);
        word_t_next = word_units(ew);
        elem_t_next = 10'(dot_t_next * 5'd31);
        slow_next   = ew < cw;
    end

    // stage 2: (word - elem + 9) / 19 through reciprocal, floor at one dot
    always_comb begin
        diff = word_t_reg - {1'b0, elem_t_reg} + 11'd9;
        prod = 23'(diff * RECIP_19);
        q    = prod[22:16];
        g    = (q < {2'b00, dot_t_reg}) ? {2'b00, dot_t_reg} : q;
        dot_ms_next = DUR_W'(dot_t_reg * 4'd10);
        if (slow_reg && word_t_reg > {1'b0, elem_t_reg})
            gap_unit_ms_next = DUR_W'(g * 4'd10);
        else
            gap_unit_ms_next = dot_ms_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dot_t_reg       <= 5'd6;
            word_t_reg      <= 11'd300;
            elem_t_reg      <= 10'd186;
            slow_reg        <= 1'b0;
            dot_ms_reg      <= 16'd60;
            gap_unit_ms_reg <= 16'd60;
        end else begin
            dot_t_reg       <= dot_t_next;
            word_t_reg      <= word_t_next;
            elem_t_reg      <= elem_t_next;
            slow_reg        <= slow_next;
            dot_ms_reg      <= dot_ms_next;
            gap_unit_ms_reg <= gap_unit_ms_next;
        end
    end

    assign dot_ms = dot_ms_reg;
    assign gap_ms = gap_unit_ms_reg;
    assign beeps  = (int'(beep_count_reg) > MAX_BEEPS) ? BEEP_W'(MAX_BEEPS)
                                                        : BEEP_W'(beep_count_reg);

endmodule

[sv/mkf_datapath.sv]
// item registers, counters and output register of the keyer
module mkf_datapath
    import mkf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mkf_cmd_t          cmd,
    input  logic [7:0]        in_char,
    input  logic              in_som,
    input  logic [DUR_W-1:0]  dot_ms,
    input  logic [DUR_W-1:0]  gap_ms,
    input  logic [BEEP_W-1:0] beeps,
    input  logic              out_ready,
    output mkf_status_t       status,
    output logic              out_valid,
    output logic              out_key,
    output logic [DUR_W-1:0]  out_dur,
    output logic              out_pre,
    output logic              out_last
);

    logic              som_reg;
    logic              space_reg;
    logic [7:0]        code_reg;
    logic [ELEM_W-1:0] len_reg;
    logic              prev_reg;
    logic [BEEP_W-1:0] beep_idx_reg;
    logic [ELEM_W-1:0] elem_idx_reg;

    logic              out_valid_reg;
    logic              out_key_reg, out_key_next;
    logic [DUR_W-1:0]  out_dur_reg, out_dur_next;
    logic              out_pre_reg, out_pre_next;
    logic              out_last_reg, out_last_next;

    logic [7:0]        in_code;
    logic [ELEM_W-1:0] bit_sel;
    logic              dash;
    logic [DUR_W-1:0]  dot3, dot5, gap3, gap7;

    assign in_code = lookup_code(in_char);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_reg     <= 1'b0;
            beep_idx_reg <= '0;
            elem_idx_reg <= '0;
        end else begin
            if (cmd.load) begin
                beep_idx_reg <= '0;
                elem_idx_reg <= '0;
                if (in_som)
                    prev_reg <= 1'b0;
            end
            if (cmd.inc_beep)
                beep_idx_reg <= beep_idx_reg + 1'b1;
            if (cmd.inc_elem)
                elem_idx_reg <= elem_idx_reg + 1'b1;
            if (cmd.set_prev)
                prev_reg <= 1'b1;
            if (cmd.clr_prev)
                prev_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            som_reg   <= in_som;
            space_reg <= (in_char == 8'h20);
            code_reg  <= in_code;
            len_reg   <= code_len(in_code);
        end
    end

    always_comb begin
        status.som        = som_reg;
        status.beeps_zero = (beeps == '0);
        status.beep_last  = ({1'b0, beep_idx_reg} + 1'b1) == {1'b0, beeps};
        status.is_space   = space_reg;
        status.prev_sym   = prev_reg;
        status.no_elems   = (len_reg == '0);
        status.elem_last  = ({1'b0, elem_idx_reg} + 1'b1) == {1'b0, len_reg};
        status.out_free   = !out_valid_reg || out_ready;
    end

    // elements go out msb first below the marker bit
    assign bit_sel = len_reg - 1'b1 - elem_idx_reg;
    assign dash    = code_reg[bit_sel];

    assign dot3 = DUR_W'({dot_ms, 1'b0}) + dot_ms;
    assign dot5 = DUR_W'({dot_ms, 2'b00}) + dot_ms;
    assign gap3 = DUR_W'({gap_ms, 1'b0}) + gap_ms;
    assign gap7 = DUR_W'({gap_ms, 3'b000}) - gap_ms;

    always_comb begin
        out_key_next  = 1'b0;
        out_dur_next  = '0;
        out_pre_next  = 1'b0;
        out_last_next = 1'b0;
        case (cmd.seg)
            SEG_BEEP_ON: begin
                out_key_next = 1'b1;
                out_dur_next = dot3;
                out_pre_next = 1'b1;
            end
            SEG_BEEP_OFF: begin
                out_dur_next = dot5;
                out_pre_next = 1'b1;
            end
            SEG_PRE_GAP: begin
                out_dur_next  = gap3;
                out_pre_next  = 1'b1;
                // unknown character after the preamble adds nothing
                out_last_next = !space_reg && (len_reg == '0);
            end
            SEG_SPACE: begin
                out_dur_next  = gap7;
                out_last_next = 1'b1;
            end
            SEG_LGAP: begin
                out_dur_next  = gap3;
                out_last_next = (len_reg == '0);
            end
            SEG_ELEM_ON: begin
                out_key_next  = 1'b1;
                out_dur_next  = dash ? dot3 : dot_ms;
                out_last_next = status.elem_last;
            end
            SEG_ELEM_OFF: begin
                out_dur_next = dot_ms;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (cmd.emit) begin
            out_key_reg  <= out_key_next;
            out_dur_reg  <= out_dur_next;
            out_pre_reg  <= out_pre_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_dur   = out_dur_reg;
    assign out_pre   = out_pre_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/mkf_ctrl.sv]
// segment sequencer state machine
module mkf_ctrl
    import mkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mkf_status_t status,
    output mkf_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_CHAR     = 4'd2;
    localparam logic [3:0] ST_BEEP_ON  = 4'd3;
    localparam logic [3:0] ST_BEEP_OFF = 4'd4;
    localparam logic [3:0] ST_PRE_GAP  = 4'd5;
    localparam logic [3:0] ST_SPACE    = 4'd6;
    localparam logic [3:0] ST_LGAP     = 4'd7;
    localparam logic [3:0] ST_ELEM_ON  = 4'd8;
    localparam logic [3:0] ST_ELEM_OFF = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.som && !status.beeps_zero)
                    state_next = ST_BEEP_ON;
                else
                    state_next = ST_CHAR;
            end
            ST_CHAR: begin
                if (status.is_space)
                    state_next = ST_SPACE;
                else if (status.prev_sym)
                    state_next = ST_LGAP;
                else if (!status.no_elems)
                    state_next = ST_ELEM_ON;
                else begin
                    cmd.set_prev = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_BEEP_ON: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.seg    = SEG_BEEP_ON;
                    state_next = status.beep_last ? ST_PRE_GAP : ST_BEEP_OFF;
                end
            end
            ST_BEEP_OFF: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.seg      = SEG_BEEP_OFF;
                    cmd.inc_beep = 1'b1;
                    state_next   = ST_BEEP_ON;
                end
            end
            ST_PRE_GAP: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.seg    = SEG_PRE_GAP;
                    state_next = ST_CHAR;
                end
            end
            ST_SPACE: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.seg      = SEG_SPACE;
                    cmd.clr_prev = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LGAP: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.seg  = SEG_LGAP;
                    if (status.no_elems) begin
                        cmd.set_prev = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_ELEM_ON;
                    end
                end
            end
            ST_ELEM_ON: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.seg  = SEG_ELEM_ON;
                    if (status.elem_last) begin
                        cmd.set_prev = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_ELEM_OFF;
                    end
                end
            end
            ST_ELEM_OFF: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.seg      = SEG_ELEM_OFF;
                    cmd.inc_elem = 1'b1;
                    state_next   = ST_ELEM_ON;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/morse_keyer_farnsworth.sv]
// top level of the farnsworth morse keyer
//
//   channel   dir   beat contents
//   char_in   in    char_code[7:0], start_of_message
//   seg_out   out   tone_on, duration_ms[15:0], is_preamble, last_of_run
//   cfg       in    cfg_we, cfg_index[1:0], cfg_wdata[5:0] (write only)
//
// an item is loaded in idle, passes the start and char states, then emits its
// segments, up to 16 preamble beeps and a 6 element character. the sequencer
// hands one segment per cycle to the output register; a stalled seg_out holds
// it. dot and gap lengths follow a register write through the timing pipeline
// registers and reset to their defaults. char_in is ready only between items
module morse_keyer_farnsworth
    import mkf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mkf_char_if.sink             char_in,
    mkf_seg_if.source            seg_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WPM_W-1:0]     cfg_wdata
);

    mkf_cmd_t          cmd;
    mkf_status_t       status;
    logic [DUR_W-1:0]  dot_ms;
    logic [DUR_W-1:0]  gap_ms;
    logic [BEEP_W-1:0] beeps;

    mkf_timing u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .dot_ms    (dot_ms),
        .gap_ms    (gap_ms),
        .beeps     (beeps)
    );

    mkf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mkf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_char   (char_in.char_code),
        .in_som    (char_in.start_of_message),
        .dot_ms    (dot_ms),
        .gap_ms    (gap_ms),
        .beeps     (beeps),
        .out_ready (seg_out.ready),
        .status    (status),
        .out_valid (seg_out.valid),
        .out_key   (seg_out.tone_on),
        .out_dur   (seg_out.duration_ms),
        .out_pre   (seg_out.is_preamble),
        .out_last  (seg_out.last_of_run)
    );

endmodule

[dv/morse_keyer_farnsworth_tb.sv]
// self-checking testbench for the farnsworth morse keyer: predicts key segments per character
module morse_keyer_farnsworth_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mkf_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] WORD_SLASH = 8'h32;
    localparam logic [7:0] WORD_DASH  = 8'h61;

    // code words, A first / 0 first at the msb end: marker bit then elements, 1 = dash
    localparam logic [8*26-1:0] LETTER_WORDS = {
        8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10, 8'h04, 8'h17, 8'h0D,
        8'h14, 8'h07, 8'h06, 8'h0F, 8'h16, 8'h1D, 8'h0A, 8'h08, 8'h03, 8'h09, 8'h11,
        8'h0B, 8'h19, 8'h1B, 8'h1C};
    localparam logic [8*10-1:0] DIGIT_WORDS = {
        8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38, 8'h3C, 8'h3E};

    localparam int DOT_NUMERATOR = 120;
    localparam int MS_PER_UNIT   = 10;
    localparam int PARIS_UNITS   = 50;
    localparam int PARIS_MARKS   = 31;
    localparam int PARIS_GAPS    = 19;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] duration_ms;
        logic        is_preamble;
        logic        last_of_run;
    } seg_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WPM_W-1:0]     cfg_wdata;

    bit src_idle     = 1'b1;
    bit sink_idle    = 1'b1;
    bit hold_request = 1'b0;
    int err_count    = 0;
    int idle_cycles  = 0;

    // keyer state as predicted
    logic [WPM_W-1:0]  char_speed;
    logic [WPM_W-1:0]  eff_speed;
    logic [BCNT_W-1:0] beep_setting;
    logic              after_symbol;
    logic [15:0]       dot_len_ms;
    logic [15:0]       gap_len_ms;

    seg_beat_t seg_expect[$];

    string SYMBOLS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789/-";

    mkf_char_if char_in();
    mkf_seg_if  seg_out();

    morse_keyer_farnsworth DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .seg_out   (seg_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int usable_wpm(input logic [WPM_W-1:0] w);
        if (w < WPM_LOW || w > WPM_HIGH)
            return int'(WPM_DEFAULT);
        return int'(w);
    endfunction

    function automatic void recompute_timing();
        int cw;
        int ew;
        int dot_units_n;
        int word_t;
        int marks_t;
        int g;
        cw = usable_wpm(char_speed);
        ew = usable_wpm(eff_speed);
        dot_units_n = (DOT_NUMERATOR + cw / 2) / cw;
        dot_len_ms = 16'(dot_units_n * MS_PER_UNIT);
        gap_len_ms = dot_len_ms;
        if (ew < cw) begin
            word_t = (DOT_NUMERATOR * PARIS_UNITS + ew / 2) / ew;
            marks_t = dot_units_n * PARIS_MARKS;
            if (word_t > marks_t) begin
                g = (word_t - marks_t + PARIS_GAPS / 2) / PARIS_GAPS;
                if (g < dot_units_n)
                    g = dot_units_n;
                gap_len_ms = 16'(g * MS_PER_UNIT);
            end
        end
    endfunction

    function automatic void keyer_reset();
        char_speed   = WPM_DEFAULT;
        eff_speed    = WPM_DEFAULT;
        beep_setting = '0;
        after_symbol = 1'b0;
        recompute_timing();
    endfunction

    function automatic logic [7:0] code_word(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (u >= "A" && u <= "Z")
            return LETTER_WORDS[8 * (25 - int'(u - "A")) +: 8];
        if (u >= "0" && u <= "9")
            return DIGIT_WORDS[8 * (9 - int'(u - "0")) +: 8];
        if (u == CHAR_SLASH)
            return WORD_SLASH;
        if (u == CHAR_DASH)
            return WORD_DASH;
        return 8'h00;
    endfunction

    function automatic void push_seg(input logic key, input int ms, input logic pre);
        seg_beat_t s;
        s.tone_on     = key;
        s.duration_ms = 16'(ms);
        s.is_preamble = pre;
        s.last_of_run = 1'b0;
        seg_expect.push_back(s);
    endfunction

    function automatic void predict_segments(input logic [7:0] c, input logic som);
        int start_sz;
        int beeps;
        int len;
        int dot;
        int gap;
        logic [7:0] word;
        start_sz = seg_expect.size();
        dot = int'(dot_len_ms);
        gap = int'(gap_len_ms);
        if (som) begin
            beeps = (int'(beep_setting) > MAX_BEEPS) ? MAX_BEEPS : int'(beep_setting);
            after_symbol = 1'b0;
            for (int b = 0; b < beeps; b++) begin
                push_seg(1'b1, dot * 3, 1'b1);
                if (b + 1 < beeps)
                    push_seg(1'b0, dot * 5, 1'b1);
            end
            if (beeps > 0)
                push_seg(1'b0, gap * 3, 1'b1);
        end
        if (c == CHAR_SPACE) begin
            push_seg(1'b0, gap * 7, 1'b0);
            after_symbol = 1'b0;
        end else begin
            word = code_word(c);
            // unknown characters still take the letter gap
            if (after_symbol)
                push_seg(1'b0, gap * 3, 1'b0);
            len = 0;
            for (int i = 1; i < 8; i++)
                if (word[i])
                    len = i;
            if (len > MAX_ELEMENTS)
                len = MAX_ELEMENTS;
            for (int e = len - 1; e >= 0; e--) begin
                push_seg(1'b1, word[e] ? dot * 3 : dot, 1'b0);
                if (e > 0)
                    push_seg(1'b0, dot, 1'b0);
            end
            after_symbol = 1'b1;
        end
        if (seg_expect.size() > start_sz)
            seg_expect[seg_expect.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic check_segment();
        seg_beat_t want;
        if (seg_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected beat key=%0b dur=%0d pre=%0b last=%0b",
                seg_out.tone_on, seg_out.duration_ms, seg_out.is_preamble,
                seg_out.last_of_run));
        end else begin
            want = seg_expect.pop_front();
            if (seg_out.tone_on !== want.tone_on)
                report_mismatch($sformatf("tone_on got %0b want %0b",
                    seg_out.tone_on, want.tone_on));
            if (seg_out.duration_ms !== want.duration_ms)
                report_mismatch($sformatf("duration_ms got %0d want %0d",
                    seg_out.duration_ms, want.duration_ms));
            if (seg_out.is_preamble !== want.is_preamble)
                report_mismatch($sformatf("is_preamble got %0b want %0b",
                    seg_out.is_preamble, want.is_preamble));
            if (seg_out.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run got %0b want %0b",
                    seg_out.last_of_run, want.last_of_run));
        end
    endtask

    // output beats first, then the new character
    always @(posedge clk) begin
        if (seg_out.valid === 1'b1 && seg_out.ready === 1'b1)
            check_segment();
        if (char_in.valid === 1'b1 && char_in.ready === 1'b1)
            predict_segments(char_in.char_code, char_in.start_of_message);
    end

    always @(posedge clk) begin
        if ((char_in.valid === 1'b1 && char_in.ready === 1'b1) ||
            (seg_out.valid === 1'b1 && seg_out.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // segment receiver: random stalls, plus one long hold-off on request
    initial begin
        seg_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                seg_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                seg_out.ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                seg_out.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                seg_out.ready <= 1'b1;
            end else begin
                seg_out.ready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic som);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            char_in.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        char_in.valid            <= 1'b1;
        char_in.char_code        <= c;
        char_in.start_of_message <= som;
        @(posedge clk);
        while (char_in.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic end_stream();
        char_in.valid <= 1'b0;
    endtask

    task automatic wait_for_quiet();
        // let the prediction of the last accepted character land first
        @(posedge clk);
        while (seg_expect.size() != 0)
            @(posedge clk);
        // a character with no segments may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WPM_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_CHAR_WPM:   char_speed   = data;
            CFG_FARNS_WPM:  eff_speed    = data;
            CFG_BEEP_COUNT: beep_setting = data[BCNT_W-1:0];
            default: ;
        endcase
        recompute_timing();
    endtask

    task automatic configure(input logic [WPM_W-1:0] cw, input logic [WPM_W-1:0] ew,
                             input logic [WPM_W-1:0] beeps, input bit poke_unused);
        wait_for_quiet();
        write_reg(CFG_CHAR_WPM, cw);
        write_reg(CFG_FARNS_WPM, ew);
        write_reg(CFG_BEEP_COUNT, beeps);
        if (poke_unused)
            write_reg(CFG_UNUSED, 6'($urandom_range(0, 63)));
        cfg_we <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_random();
        logic [WPM_W-1:0] cw;
        logic [WPM_W-1:0] ew;
        logic [WPM_W-1:0] beeps;
        case ($urandom_range(0, 5))
            0: begin cw = 6'd60; ew = 6'd5; end
            1: begin cw = 6'd5; ew = 6'd60; end
            2: begin cw = 6'($urandom_range(5, 60)); ew = 6'($urandom_range(5, 60)); end
            3: begin cw = 6'($urandom_range(0, 63)); ew = 6'($urandom_range(0, 63)); end
            4: begin cw = 6'($urandom_range(6, 60)); ew = 6'($urandom_range(5, cw - 1)); end
            default: begin cw = 6'($urandom_range(5, 60)); ew = cw; end
        endcase
        // long preambles are slow, keep most of them short
        beeps = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 4));
        configure(cw, ew, beeps, $urandom_range(0, 2) == 0);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)];
        if (r < 80)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // a message opens with start_of_message, with a stray restart now and then
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_char(pick_char(), (k == 0) || ($urandom_range(0, 19) == 0));
    endtask

    task automatic test_reset_defaults();
        send_char("P", 1'b1);
        send_char("a", 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("9", 1'b0);
        end_stream();
    endtask

    task automatic test_speed_extremes();
        // beep count of 31 saturates to the maximum
        configure(6'd60, 6'd5, 6'd63, 1'b0);
        send_char(CHAR_DASH, 1'b1);
        send_char(CHAR_SLASH, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        end_stream();
        configure(6'd5, 6'd60, 6'd16, 1'b1);
        send_char("Z", 1'b1);
        send_char("5", 1'b0);
        end_stream();
        // out of range speeds fall back to the default
        configure(6'd0, 6'd63, 6'd1, 1'b1);
        send_char("E", 1'b1);
        send_char(8'h80, 1'b0);
        end_stream();
        configure(6'd4, 6'd61, 6'd0, 1'b0);
        send_char("T", 1'b1);
        end_stream();
    endtask

    task automatic test_silent_items();
        configure(6'd20, 6'd20, 6'd0, 1'b0);
        send_char(8'h01, 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        send_char(8'h7F, 1'b1);
        send_char("k", 1'b0);
        end_stream();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        for (int phase = 0; phase < 7; phase++) begin
            configure_random();
            sent = 0;
            while (sent < 55) begin
                len = $urandom_range(1, 10);
                send_message(len);
                sent += len;
            end
            end_stream();
        end
    endtask

    task automatic test_input_stall();
        configure(6'd20, 6'd10, 6'd4, 1'b0);
        src_idle = 1'b0;
        hold_request = 1'b1;
        send_message(12);
        send_message(13);
        end_stream();
        src_idle = 1'b1;
    endtask

    task automatic test_steady_stream();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        configure_random();
        for (int m = 0; m < 4; m++)
            send_message(10);
        end_stream();
    endtask

    initial begin
        char_in.valid            <= 1'b0;
        char_in.char_code        <= '0;
        char_in.start_of_message <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_index                <= '0;
        cfg_wdata                <= '0;
        rst_n                    <= 1'b0;
        keyer_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_reset_defaults();
        test_speed_extremes();
        test_silent_items();
        test_random_messages();
        test_input_stall();
        test_steady_stream();

        wait_for_quiet();
        if (err_count == 0 && seg_expect.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/mkf_pkg.sv
sv/mkf_char_if.sv
sv/mkf_seg_if.sv
sv/mkf_timing.sv
sv/mkf_datapath.sv
sv/mkf_ctrl.sv
sv/morse_keyer_farnsworth.sv
dv/morse_keyer_farnsworth_tb.sv
